/* design/lagged_xor_table_cipher_assert.svh */
// Assertion macros used by the cipher RTL.
`ifndef LAGGED_XOR_TABLE_CIPHER_ASSERT_SVH
`define LAGGED_XOR_TABLE_CIPHER_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define ASSERT_ON_CLOCK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);
`else
`define ASSERT_ON_CLOCK(label, prop, msg)
`define ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

/* design/ltc_pkg.sv */
`default_nettype none

package ltc_pkg;

   localparam int LAG_BYTES   = 256;
   localparam int GROUP_BYTES = 8;
   localparam int GROUP_COUNT = LAG_BYTES / GROUP_BYTES;
   localparam int GROUP_W     = $clog2(GROUP_COUNT);
   localparam int OFFSET_W    = $clog2(GROUP_BYTES);
   localparam int POS_W       = $clog2(LAG_BYTES);
   localparam int PW_BYTES    = 32;
   localparam int PW_LEN_W    = 6;
   localparam int PW_KEY_W    = $clog2(PW_BYTES);
   localparam int DATA_W      = 32;
   localparam int BYTE_W      = 8;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 64;
   localparam int SEARCH_GROUPS  = 16;
   localparam int SEARCH_GROUP_W = $clog2(SEARCH_GROUPS);
   localparam int SEARCH_SIZE    = LAG_BYTES / SEARCH_GROUPS;
   localparam int SEARCH_IDX_W   = $clog2(SEARCH_SIZE);

   localparam logic [CSR_INDEX_W-1:0] CSR_MODE      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PW_WORD_0 = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PW_WORD_1 = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PW_WORD_2 = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_PW_WORD_3 = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_PW_LEN    = 3'd5;

   localparam logic MODE_ENCRYPT = 1'b0;
   localparam logic MODE_DECRYPT = 1'b1;

   typedef logic [GROUP_W-1:0] group_type;
   typedef logic [BYTE_W-1:0]  byte_type;
   typedef logic [DATA_W-1:0]  word_type;

   typedef struct packed {
      logic      busy;
      logic      rd_en;
      group_type rd_addr_a;
      group_type rd_addr_b;
      logic      wr_en;
      group_type wr_addr;
      group_type wr_data;
   } perm_ctl_type;

   localparam byte_type KEY_BASE [LAG_BYTES] = '{
      8'd44, 8'd34, 8'd24, 8'd14, 8'd4, 8'd42, 8'd32, 8'd22, 8'd12, 8'd2,
      8'd19, 8'd7, 8'd47, 8'd17, 8'd5, 8'd43, 8'd37, 8'd29, 8'd13, 8'd3,
      8'd41, 8'd31, 8'd23, 8'd11, 8'd0, 8'd1, 8'd6, 8'd8, 8'd9, 8'd10,
      8'd15, 8'd16, 8'd18, 8'd20, 8'd21, 8'd25, 8'd26, 8'd27, 8'd28, 8'd30,
      8'd33, 8'd35, 8'd36, 8'd38, 8'd39, 8'd40, 8'd45, 8'd46, 8'd48, 8'd49,
      8'd94, 8'd84, 8'd74, 8'd64, 8'd54, 8'd92, 8'd82, 8'd72, 8'd62, 8'd52,
      8'd79, 8'd59, 8'd97, 8'd89, 8'd73, 8'd67, 8'd53, 8'd91, 8'd83, 8'd71,
      8'd61, 8'd51, 8'd50, 8'd55, 8'd56, 8'd57, 8'd58, 8'd60, 8'd63, 8'd65,
      8'd66, 8'd68, 8'd69, 8'd70, 8'd75, 8'd76, 8'd77, 8'd78, 8'd80, 8'd81,
      8'd85, 8'd86, 8'd87, 8'd88, 8'd90, 8'd93, 8'd95, 8'd96, 8'd98, 8'd99,
      8'd144, 8'd134, 8'd124, 8'd114, 8'd104, 8'd142, 8'd132, 8'd122, 8'd112, 8'd102,
      8'd139, 8'd107, 8'd137, 8'd127, 8'd103, 8'd149, 8'd131, 8'd123, 8'd113, 8'd101,
      8'd100, 8'd105, 8'd106, 8'd108, 8'd109, 8'd110, 8'd111, 8'd115, 8'd116, 8'd117,
      8'd118, 8'd119, 8'd120, 8'd121, 8'd125, 8'd126, 8'd128, 8'd129, 8'd130, 8'd133,
      8'd135, 8'd136, 8'd138, 8'd140, 8'd141, 8'd143, 8'd145, 8'd146, 8'd147, 8'd148,
      8'd194, 8'd184, 8'd174, 8'd164, 8'd154, 8'd192, 8'd182, 8'd172, 8'd162, 8'd152,
      8'd199, 8'd197, 8'd193, 8'd179, 8'd167, 8'd157, 8'd191, 8'd181, 8'd173, 8'd163,
      8'd151, 8'd150, 8'd153, 8'd155, 8'd156, 8'd158, 8'd159, 8'd160, 8'd161, 8'd165,
      8'd166, 8'd168, 8'd169, 8'd170, 8'd171, 8'd175, 8'd176, 8'd177, 8'd178, 8'd180,
      8'd183, 8'd185, 8'd186, 8'd187, 8'd188, 8'd189, 8'd190, 8'd195, 8'd196, 8'd198,
      8'd254, 8'd244, 8'd234, 8'd224, 8'd214, 8'd204, 8'd252, 8'd242, 8'd232, 8'd222,
      8'd212, 8'd202, 8'd239, 8'd227, 8'd251, 8'd241, 8'd233, 8'd223, 8'd211, 8'd209,
      8'd200, 8'd201, 8'd203, 8'd205, 8'd206, 8'd207, 8'd208, 8'd210, 8'd213, 8'd215,
      8'd216, 8'd217, 8'd218, 8'd219, 8'd220, 8'd221, 8'd225, 8'd226, 8'd228, 8'd229,
      8'd230, 8'd231, 8'd235, 8'd236, 8'd237, 8'd238, 8'd240, 8'd243, 8'd245, 8'd246,
      8'd247, 8'd248, 8'd249, 8'd250, 8'd253, 8'd255
   };

   localparam word_type WORD_TABLE [LAG_BYTES] = '{
      32'h46733436, 32'h59763833, 32'h50673432, 32'h44623937,
      32'h41783435, 32'h42663438, 32'h43713135, 32'h51743039,
      32'h4C7a3737, 32'h577a3635, 32'h58693139, 32'h59753336,
      32'h46733733, 32'h45683235, 32'h42753730, 32'h55743235,
      32'h55643533, 32'h47653334, 32'h55623237, 32'h50673036,
      32'h54653739, 32'h42643331, 32'h4E6c3738, 32'h58633838,
      32'h56673733, 32'h41763032, 32'h4F633934, 32'h4C613136,
      32'h456c3935, 32'h566e3232, 32'h4A713730, 32'h49753538,
      32'h4A623333, 32'h58623832, 32'h4B753039, 32'h436b3731,
      32'h51703736, 32'h4E773836, 32'h5A753137, 32'h57713232,
      32'h4A663630, 32'h4D783439, 32'h54663832, 32'h54793136,
      32'h4B793238, 32'h4E6d3731, 32'h4D763638, 32'h4C6e3233,
      32'h536d3631, 32'h506d3530, 32'h54693738, 32'h53683735,
      32'h42683036, 32'h4C6b3231, 32'h44673239, 32'h4C6d3736,
      32'h497a3939, 32'h46633336, 32'h58733131, 32'h4F703636,
      32'h5A683232, 32'h417a3135, 32'h43643434, 32'h55753734,
      32'h42683131, 32'h45613830, 32'h57673537, 32'h42773137,
      32'h596b3134, 32'h54673135, 32'h4D793639, 32'h48783032,
      32'h4E683734, 32'h4F6d3037, 32'h446c3233, 32'h4B743631,
      32'h5A613137, 32'h4F763737, 32'h4B773937, 32'h566f3939,
      32'h54683131, 32'h4C753237, 32'h46613837, 32'h486b3230,
      32'h56633534, 32'h5A703834, 32'h546b3031, 32'h486b3939,
      32'h54703037, 32'h56653036, 32'h4C7a3338, 32'h47793136,
      32'h44633534, 32'h4A6a3737, 32'h46723237, 32'h58683936,
      32'h53723533, 32'h5A613237, 32'h53653435, 32'h4D6b3032,
      32'h45763139, 32'h4B703936, 32'h4C653332, 32'h456d3934,
      32'h4D643532, 32'h4C753231, 32'h486f3833, 32'h43633034,
      32'h54763833, 32'h47753837, 32'h506a3831, 32'h43783532,
      32'h4D6e3936, 32'h54683333, 32'h55753934, 32'h51753235,
      32'h466d3838, 32'h57643235, 32'h59793135, 32'h56653033,
      32'h4E723134, 32'h5A7a3939, 32'h52633138, 32'h41673139,
      32'h4A6f3633, 32'h56713936, 32'h58683032, 32'h49783133,
      32'h49653438, 32'h57683331, 32'h4D6d3631, 32'h56653130,
      32'h41693039, 32'h55713336, 32'h4F623836, 32'h48683738,
      32'h4B723937, 32'h53793631, 32'h47693936, 32'h50753033,
      32'h42713039, 32'h586f3934, 32'h4B6d3835, 32'h53793836,
      32'h42793530, 32'h54743439, 32'h487a3531, 32'h41753830,
      32'h416a3334, 32'h50653231, 32'h466d3330, 32'h476b3938,
      32'h596b3232, 32'h55723437, 32'h4F733832, 32'h43763736,
      32'h5A6a3034, 32'h54773130, 32'h46673830, 32'h45763337,
      32'h56733834, 32'h45663737, 32'h4C7a3138, 32'h556a3932,
      32'h566e3632, 32'h48683536, 32'h56633131, 32'h59763532,
      32'h576f3835, 32'h4E673231, 32'h586b3534, 32'h41763734,
      32'h4A7a3332, 32'h47703735, 32'h4A673132, 32'h56793137,
      32'h57623436, 32'h49703038, 32'h4F6c3538, 32'h567a3531,
      32'h446d3333, 32'h486d3334, 32'h586e3935, 32'h47723837,
      32'h55783338, 32'h4D763939, 32'h54773632, 32'h4A623938,
      32'h48643832, 32'h47793033, 32'h4E663437, 32'h4D6c3834,
      32'h566c3239, 32'h55653231, 32'h4F663732, 32'h45703833,
      32'h586e3832, 32'h4C633130, 32'h55713831, 32'h4D623632,
      32'h586d3833, 32'h47703732, 32'h52673438, 32'h5A7a3739,
      32'h46773130, 32'h42753130, 32'h58783832, 32'h4D613630,
      32'h4D763234, 32'h41733630, 32'h4A703537, 32'h4A633335,
      32'h45763832, 32'h47663332, 32'h4B633335, 32'h41623632,
      32'h4C6d3132, 32'h546b3436, 32'h42713834, 32'h466e3135,
      32'h556a3838, 32'h41733831, 32'h55623839, 32'h5A6a3332,
      32'h5A743533, 32'h55703932, 32'h50693330, 32'h4A783931,
      32'h556b3933, 32'h516c3133, 32'h53693132, 32'h42643437,
      32'h566f3835, 32'h53743434, 32'h5A6a3635, 32'h55713238,
      32'h58683537, 32'h5A783234, 32'h4D6f3030, 32'h506e3730,
      32'h44643938, 32'h55663038, 32'h45623338, 32'h4F723835,
      32'h46653635, 32'h4D6f3530, 32'h496b3934, 32'h44673331,
      32'h53703730, 32'h45643832, 32'h426d3635, 32'h43663936,
      32'h45723234, 32'h43753537, 32'h47713130, 32'h55713733
   };

endpackage

`default_nettype wire

/* design/ltc_ram.sv */
`default_nettype none

module ltc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic                     rd_en_b,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en_a) begin
         rd_data_a_ff <= mem_ff[rd_addr_a];
      end
      if (rd_en_b) begin
         rd_data_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

`default_nettype wire

/* design/ltc_cell.sv */
`default_nettype none

module ltc_cell #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             shift_en,
   input  logic [WIDTH-1:0] from_prev,
   output logic [WIDTH-1:0] to_next
);

   logic [WIDTH-1:0] hold_ff;
   logic [WIDTH-1:0] hold_in;

   assign hold_in = shift_en ? from_prev : hold_ff;

   always_ff @(posedge clock) begin
      hold_ff <= hold_in;
   end

   assign to_next = hold_ff;

endmodule

`default_nettype wire

/* design/ltc_perm_seq.sv */
`default_nettype none

module ltc_perm_seq (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     start,
   input  logic [ltc_pkg::PW_BYTES*ltc_pkg::BYTE_W-1:0] password,
   input  logic [ltc_pkg::PW_LEN_W-1:0]             pw_len,
   input  ltc_pkg::group_type                       rd_data_a,
   input  ltc_pkg::group_type                       rd_data_b,
   output ltc_pkg::perm_ctl_type                    ctl
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_INIT,
      S_READ,
      S_SWAP_I,
      S_SWAP_J
   } seq_state_type;

   localparam ltc_pkg::group_type LAST_STEP = ltc_pkg::GROUP_W'(ltc_pkg::GROUP_COUNT - 1);

   seq_state_type                    state_ff, state_in;
   ltc_pkg::group_type               step_ff, step_in;
   logic [ltc_pkg::PW_KEY_W-1:0]     key_pos_ff, key_pos_in;
   ltc_pkg::group_type               swap_j_ff, swap_j_in;
   ltc_pkg::group_type               held_ff, held_in;
   ltc_pkg::byte_type                pw_sel;
   logic [ltc_pkg::PW_LEN_W-1:0]     key_pos_next;

   assign pw_sel = password[{key_pos_ff, 3'b000} +: ltc_pkg::BYTE_W];
   assign key_pos_next = ltc_pkg::PW_LEN_W'(key_pos_ff) + 1'b1;

   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      key_pos_in = key_pos_ff;
      swap_j_in  = swap_j_ff;
      held_in    = held_ff;
      unique case (state_ff)
         S_IDLE: begin
         end
         S_INIT: begin
            step_in = step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               state_in   = S_READ;
               step_in    = '0;
               key_pos_in = '0;
            end
         end
         S_READ: begin
            swap_j_in = pw_sel[ltc_pkg::GROUP_W-1:0];
            state_in  = S_SWAP_I;
         end
         S_SWAP_I: begin
            held_in  = rd_data_a;
            state_in = S_SWAP_J;
         end
         S_SWAP_J: begin
            if (step_ff == LAST_STEP) begin
               state_in = S_IDLE;
            end else begin
               step_in    = step_ff + 1'b1;
               key_pos_in = (key_pos_next == pw_len) ? '0 : key_pos_next[ltc_pkg::PW_KEY_W-1:0];
               state_in   = S_READ;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (start) begin
         state_in = S_INIT;
         step_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_INIT;
         step_ff    <= '0;
         key_pos_ff <= '0;
      end else begin
         state_ff   <= state_in;
         step_ff    <= step_in;
         key_pos_ff <= key_pos_in;
      end
      swap_j_ff <= swap_j_in;
      held_ff   <= held_in;
   end

   always_comb begin
      ctl.busy      = (state_ff != S_IDLE) || start;
      ctl.rd_en     = (state_ff == S_READ);
      ctl.rd_addr_a = step_ff;
      ctl.rd_addr_b = pw_sel[ltc_pkg::GROUP_W-1:0];
      ctl.wr_en     = 1'b0;
      ctl.wr_addr   = step_ff;
      ctl.wr_data   = step_ff;
      unique case (state_ff)
         S_INIT: begin
            ctl.wr_en = 1'b1;
         end
         S_SWAP_I: begin
            ctl.wr_en   = 1'b1;
            ctl.wr_data = rd_data_b;
         end
         S_SWAP_J: begin
            ctl.wr_en   = 1'b1;
            ctl.wr_addr = swap_j_ff;
            ctl.wr_data = held_ff;
         end
         default: begin
         end
      endcase
   end

endmodule

`default_nettype wire

/* design/lagged_xor_table_cipher.sv */
// Streaming byte cipher with a 256-item lag. Items enter on the req_ channel and one result
// item leaves on the rsp_ channel for each, in order, via stage 1, stage 2 and the output
// register. Outside a permutation rebuild the pipeline takes one item per cycle and keeps
// that rate while results are stalled until its three stages fill. The plaintext history is
// a row of 256 byte cells that shifts once per item, so the byte 256 positions back always
// sits in the last cell. After reset, and after every write to a password register or to
// the password length, the group permutation is rebuilt in a small RAM with req_stall high: the
// identity order is loaded, then each of the 32 swaps runs its read, swap-i and swap-j states.
// Configuration writes take effect on the next item; message position and history are kept.
`default_nettype none

`include "lagged_xor_table_cipher_assert.svh"

module lagged_xor_table_cipher (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [ltc_pkg::DATA_W-1:0]         req_data_in,
   input  logic                               req_last_in,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [ltc_pkg::DATA_W-1:0]         rsp_data_out,
   output logic                               rsp_invalid_word,
   output logic                               rsp_last_out,
   input  logic                               csr_write_enable,
   input  logic [ltc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [ltc_pkg::CSR_DATA_W-1:0]     csr_write_data
);

   localparam int SG = ltc_pkg::SEARCH_GROUPS;
   localparam int SS = ltc_pkg::SEARCH_SIZE;

   // Configuration registers.
   logic                                mode_ff;
   logic [ltc_pkg::CSR_DATA_W-1:0]      pw_word_ff [4];
   logic [ltc_pkg::PW_LEN_W-1:0]        pw_len_ff;
   logic [ltc_pkg::PW_LEN_W-1:0]        pw_eff_len;
   logic [ltc_pkg::PW_BYTES*ltc_pkg::BYTE_W-1:0] pw_flat;
   logic                                perm_start;

   // Permutation store and its builder.
   ltc_pkg::perm_ctl_type               seq_ctl;
   ltc_pkg::group_type                  perm_rd_a;
   ltc_pkg::group_type                  perm_rd_b;
   logic                                ram_rd_en_a;
   ltc_pkg::group_type                  ram_rd_addr_a;

   // Message position.
   logic [ltc_pkg::POS_W-1:0]           pos_ff, pos_in;
   logic                                past_ff, past_in;

   // Flow control.
   logic                                accept;
   logic                                out_ready;
   logic                                s2_ready;
   logic                                s1_ready;
   logic                                s2_adv;

   // Stage 1.
   logic                                s1_valid_ff, s1_valid_in;
   logic                                s1_mode_ff;
   logic                                s1_last_ff;
   logic                                s1_past_ff;
   ltc_pkg::byte_type                   s1_byte_ff;
   logic [ltc_pkg::OFFSET_W-1:0]        s1_offset_ff;
   logic [SG-1:0]                       s1_hit_ff;
   logic [ltc_pkg::SEARCH_IDX_W-1:0]    s1_idx_ff [SG];
   logic [SG-1:0]                       grp_hit;
   logic [ltc_pkg::SEARCH_IDX_W-1:0]    grp_idx [SG];
   logic                                s1_found;
   ltc_pkg::byte_type                   s1_index;
   ltc_pkg::byte_type                   s1_key;

   // Stage 2.
   logic                                s2_valid_ff, s2_valid_in;
   logic                                s2_mode_ff;
   logic                                s2_last_ff;
   logic                                s2_past_ff;
   ltc_pkg::byte_type                   s2_byte_ff;
   ltc_pkg::byte_type                   s2_key_ff;
   logic                                s2_found_ff;
   ltc_pkg::byte_type                   s2_index_ff;
   ltc_pkg::byte_type                   pad;
   ltc_pkg::byte_type                   dec_byte;
   ltc_pkg::byte_type                   hist_byte;
   ltc_pkg::word_type                   s2_data;
   logic                                s2_invalid;

   // History chain.
   ltc_pkg::byte_type                   chain [ltc_pkg::LAG_BYTES];

   // Output register.
   logic                                rsp_valid_ff, rsp_valid_in;
   ltc_pkg::word_type                   rsp_data_ff;
   logic                                rsp_invalid_ff;
   logic                                rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= ltc_pkg::MODE_ENCRYPT;
         pw_word_ff[0] <= '0;
         pw_word_ff[1] <= '0;
         pw_word_ff[2] <= '0;
         pw_word_ff[3] <= '0;
         pw_len_ff     <= ltc_pkg::PW_LEN_W'(1);
      end else if (csr_write_enable) begin
         unique case (csr_index)
            ltc_pkg::CSR_MODE:      mode_ff       <= csr_write_data[0];
            ltc_pkg::CSR_PW_WORD_0: pw_word_ff[0] <= csr_write_data;
            ltc_pkg::CSR_PW_WORD_1: pw_word_ff[1] <= csr_write_data;
            ltc_pkg::CSR_PW_WORD_2: pw_word_ff[2] <= csr_write_data;
            ltc_pkg::CSR_PW_WORD_3: pw_word_ff[3] <= csr_write_data;
            ltc_pkg::CSR_PW_LEN:    pw_len_ff     <= csr_write_data[ltc_pkg::PW_LEN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign pw_flat = {pw_word_ff[3], pw_word_ff[2], pw_word_ff[1], pw_word_ff[0]};

   always_comb begin
      if (pw_len_ff == '0) begin
         pw_eff_len = ltc_pkg::PW_LEN_W'(1);
      end else if (pw_len_ff > ltc_pkg::PW_LEN_W'(ltc_pkg::PW_BYTES)) begin
         pw_eff_len = ltc_pkg::PW_LEN_W'(ltc_pkg::PW_BYTES);
      end else begin
         pw_eff_len = pw_len_ff;
      end
   end

   assign perm_start = csr_write_enable &&
                       ((csr_index == ltc_pkg::CSR_PW_WORD_0) ||
                        (csr_index == ltc_pkg::CSR_PW_WORD_1) ||
                        (csr_index == ltc_pkg::CSR_PW_WORD_2) ||
                        (csr_index == ltc_pkg::CSR_PW_WORD_3) ||
                        (csr_index == ltc_pkg::CSR_PW_LEN));

   ltc_perm_seq u_perm_seq (
      .clock     (clock),
      .reset     (reset),
      .start     (perm_start),
      .password  (pw_flat),
      .pw_len    (pw_eff_len),
      .rd_data_a (perm_rd_a),
      .rd_data_b (perm_rd_b),
      .ctl       (seq_ctl)
   );

   assign ram_rd_en_a   = seq_ctl.busy ? seq_ctl.rd_en : accept;
   assign ram_rd_addr_a = seq_ctl.busy ? seq_ctl.rd_addr_a
                                       : pos_ff[ltc_pkg::POS_W-1:ltc_pkg::OFFSET_W];

   ltc_ram #(
      .WIDTH (ltc_pkg::GROUP_W),
      .DEPTH (ltc_pkg::GROUP_COUNT)
   ) u_perm_ram (
      .clock     (clock),
      .wr_en     (seq_ctl.wr_en),
      .wr_addr   (seq_ctl.wr_addr),
      .wr_data   (seq_ctl.wr_data),
      .rd_en_a   (ram_rd_en_a),
      .rd_addr_a (ram_rd_addr_a),
      .rd_data_a (perm_rd_a),
      .rd_en_b   (seq_ctl.rd_en),
      .rd_addr_b (seq_ctl.rd_addr_b),
      .rd_data_b (perm_rd_b)
   );

   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign s2_ready  = !s2_valid_ff || out_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign s2_adv    = s2_valid_ff && out_ready;
   assign req_stall = seq_ctl.busy || !s1_ready;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      pos_in  = pos_ff;
      past_in = past_ff;
      if (accept) begin
         if (req_last_in) begin
            pos_in  = '0;
            past_in = 1'b0;
         end else begin
            pos_in = pos_ff + 1'b1;
            if (pos_ff == '1) begin
               past_in = 1'b1;
            end
         end
      end
   end

   // First level of the word search: sixteen groups, lowest matching entry wins.
   always_comb begin
      for (int g = 0; g < SG; g++) begin
         grp_hit[g] = 1'b0;
         grp_idx[g] = '0;
         for (int e = SS - 1; e >= 0; e--) begin
            if (ltc_pkg::WORD_TABLE[g*SS + e] == req_data_in) begin
               grp_hit[g] = 1'b1;
               grp_idx[g] = ltc_pkg::SEARCH_IDX_W'(e);
            end
         end
      end
   end

   assign s1_valid_in = s1_ready ? accept : s1_valid_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_mode_ff   <= mode_ff;
         s1_last_ff   <= req_last_in;
         s1_past_ff   <= past_ff;
         s1_byte_ff   <= req_data_in[ltc_pkg::BYTE_W-1:0];
         s1_offset_ff <= pos_ff[ltc_pkg::OFFSET_W-1:0];
         s1_hit_ff    <= grp_hit;
         for (int g = 0; g < SG; g++) begin
            s1_idx_ff[g] <= grp_idx[g];
         end
      end
   end

   always_comb begin
      s1_found = 1'b0;
      s1_index = '0;
      for (int g = SG - 1; g >= 0; g--) begin
         if (s1_hit_ff[g]) begin
            s1_found = 1'b1;
            s1_index = {ltc_pkg::SEARCH_GROUP_W'(g), s1_idx_ff[g]};
         end
      end
   end

   assign s1_key = ltc_pkg::KEY_BASE[{perm_rd_a, s1_offset_ff}];

   assign s2_valid_in = s2_ready ? s1_valid_ff : s2_valid_ff;

   always_ff @(posedge clock) begin
      if (s1_valid_ff && s2_ready) begin
         s2_mode_ff  <= s1_mode_ff;
         s2_last_ff  <= s1_last_ff;
         s2_past_ff  <= s1_past_ff;
         s2_byte_ff  <= s1_byte_ff;
         s2_key_ff   <= s1_key;
         s2_found_ff <= s1_found;
         s2_index_ff <= s1_index;
      end
   end

   assign pad      = s2_past_ff ? chain[ltc_pkg::LAG_BYTES-1] : s2_key_ff;
   assign dec_byte = s2_index_ff ^ pad;

   always_comb begin
      if (s2_mode_ff == ltc_pkg::MODE_ENCRYPT) begin
         s2_data    = ltc_pkg::WORD_TABLE[s2_byte_ff ^ pad];
         s2_invalid = 1'b0;
         hist_byte  = s2_byte_ff;
      end else if (s2_found_ff) begin
         s2_data    = ltc_pkg::DATA_W'(dec_byte);
         s2_invalid = 1'b0;
         hist_byte  = dec_byte;
      end else begin
         s2_data    = '0;
         s2_invalid = 1'b1;
         hist_byte  = '0;
      end
   end

   for (genvar c = 0; c < ltc_pkg::LAG_BYTES; c++) begin : g_chain
      if (c == 0) begin : g_head
         ltc_cell #(.WIDTH(ltc_pkg::BYTE_W)) u_cell (
            .clock     (clock),
            .shift_en  (s2_adv),
            .from_prev (hist_byte),
            .to_next   (chain[c])
         );
      end else begin : g_body
         ltc_cell #(.WIDTH(ltc_pkg::BYTE_W)) u_cell (
            .clock     (clock),
            .shift_en  (s2_adv),
            .from_prev (chain[c-1]),
            .to_next   (chain[c])
         );
      end
   end

   assign rsp_valid_in = out_ready ? s2_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (s2_adv) begin
         rsp_data_ff    <= s2_data;
         rsp_invalid_ff <= s2_invalid;
         rsp_last_ff    <= s2_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         past_ff      <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         past_ff      <= past_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_data_out     = rsp_data_ff;
   assign rsp_invalid_word = rsp_invalid_ff;
   assign rsp_last_out     = rsp_last_ff;

   `ASSERT_ALWAYS(a_reset_rebuilds, reset |=> req_stall, "input open right after reset")
   `ASSERT_ON_CLOCK(a_pw_write_stalls, perm_start |=> req_stall, "input open after password write")
   `ASSERT_ON_CLOCK(a_last_restarts, (accept && req_last_in) |=> (pos_ff == '0 && !past_ff), "position not restarted")
   `ASSERT_ON_CLOCK(a_invalid_zero, (rsp_valid_ff && rsp_invalid_ff) |-> (rsp_data_ff == '0), "invalid item with data")

endmodule

`default_nettype wire

/* tb/tb_lagged_xor_table_cipher.sv */
`default_nettype none

module tb_lagged_xor_table_cipher;
   timeunit 1ns;
   timeprecision 1ps;

   import ltc_pkg::*;

   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_6 = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_7 = 3'd7;
   localparam int HOLD_CYCLES = 200;
   localparam int ROUND_TRIPS = 6;

   typedef struct packed {
      word_type data;
      logic     invalid;
      logic     last;
   } cipher_result_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   word_type               req_data_in = '0;
   logic                   req_last_in = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   word_type               rsp_data_out;
   logic                   rsp_invalid_word;
   logic                   rsp_last_out;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_write_data = '0;

   lagged_xor_table_cipher dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_in      (req_data_in),
      .req_last_in      (req_last_in),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data_out     (rsp_data_out),
      .rsp_invalid_word (rsp_invalid_word),
      .rsp_last_out     (rsp_last_out),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Shadow copy of the cipher state and its configuration.
   logic                  cur_mode;
   logic [CSR_DATA_W-1:0] pw_word [4];
   logic [PW_LEN_W-1:0]   pw_len;
   byte_type              hist_bytes [LAG_BYTES];
   logic [POS_W-1:0]      msg_pos;
   logic                  lag_active;
   group_type             group_order [GROUP_COUNT];

   cipher_result_type transforms_due [$];

   int  failures = 0;
   int  items_sent = 0;
   int  results_seen = 0;
   int  csr_writes = 0;
   int  invalid_items = 0;
   int  lagged_items = 0;
   bit  send_gaps = 1'b0;
   bit  rsp_gaps = 1'b0;
   int  rsp_hold_request = 0;
   int  run_left = 0;
   bit  run_is_stall = 1'b0;

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("tb_lagged_xor_table_cipher failed");
      $finish;
   end

   function automatic void rebuild_group_order();
      int        len;
      int        k;
      int        j;
      group_type t;
      len = pw_len;
      if (len == 0) len = 1;
      if (len > PW_BYTES) len = PW_BYTES;
      for (int i = 0; i < GROUP_COUNT; i++) group_order[i] = group_type'(i);
      for (int i = 0; i < GROUP_COUNT; i++) begin
         k = i % len;
         j = pw_word[k / (CSR_DATA_W / BYTE_W)][(k % (CSR_DATA_W / BYTE_W)) * BYTE_W +: BYTE_W]
             % GROUP_COUNT;
         t = group_order[i];
         group_order[i] = group_order[j];
         group_order[j] = t;
      end
   endfunction

   function automatic byte_type key_at(logic [POS_W-1:0] p);
      return KEY_BASE[{group_order[p[POS_W-1:OFFSET_W]], p[OFFSET_W-1:0]}];
   endfunction

   function automatic cipher_result_type cipher_transform(word_type d, logic l);
      cipher_result_type r;
      byte_type          pad;
      byte_type          b;
      int                hit;
      pad = lag_active ? hist_bytes[msg_pos] : key_at(msg_pos);
      r = '0;
      r.last = l;
      if (cur_mode == MODE_ENCRYPT) begin
         b = d[BYTE_W-1:0];
         r.data = WORD_TABLE[b ^ pad];
         hist_bytes[msg_pos] = b;
      end else begin
         hit = -1;
         for (int j = LAG_BYTES - 1; j >= 0; j--) begin
            if (WORD_TABLE[j] == d) hit = j;
         end
         if (hit < 0) begin
            r.invalid = 1'b1;
            hist_bytes[msg_pos] = '0;
         end else begin
            b = byte_type'(hit) ^ pad;
            r.data = word_type'(b);
            hist_bytes[msg_pos] = b;
         end
      end
      if (l) begin
         msg_pos = '0;
         lag_active = 1'b0;
      end else begin
         msg_pos = msg_pos + 1'b1;
         if (msg_pos == '0) lag_active = 1'b1;
      end
      return r;
   endfunction

   function automatic int idle_gap();
      int r;
      if (!send_gaps) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic int message_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 24);
      if (r < 90) return $urandom_range(25, 120);
      return $urandom_range(250, 400);
   endfunction

   task automatic pause_sender();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      pause_sender();
      while (transforms_due.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      pause_sender();
      while (req_stall !== 1'b0) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         CSR_MODE: cur_mode = value[0];
         CSR_PW_WORD_0, CSR_PW_WORD_1, CSR_PW_WORD_2, CSR_PW_WORD_3: begin
            pw_word[int'(idx) - int'(CSR_PW_WORD_0)] = value;
            rebuild_group_order();
         end
         CSR_PW_LEN: begin
            pw_len = value[PW_LEN_W-1:0];
            rebuild_group_order();
         end
         default: ;
      endcase
      csr_writes++;
      repeat (2) @(posedge clock);
   endtask

   task automatic set_mode(logic m);
      logic [CSR_DATA_W-1:0] v;
      v = {$urandom, $urandom};
      v[0] = m;
      write_csr(CSR_MODE, v);
   endtask

   task automatic set_length(int len);
      logic [CSR_DATA_W-1:0] v;
      v = {$urandom, $urandom};
      v[PW_LEN_W-1:0] = PW_LEN_W'(len);
      write_csr(CSR_PW_LEN, v);
   endtask

   task automatic set_password(logic [CSR_DATA_W-1:0] w0, logic [CSR_DATA_W-1:0] w1,
                               logic [CSR_DATA_W-1:0] w2, logic [CSR_DATA_W-1:0] w3,
                               int len);
      write_csr(CSR_PW_WORD_0, w0);
      write_csr(CSR_PW_WORD_1, w1);
      write_csr(CSR_PW_WORD_2, w2);
      write_csr(CSR_PW_WORD_3, w3);
      set_length(len);
   endtask

   function automatic logic [CSR_DATA_W-1:0] random_pw_word();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return '0;
      if (r == 1) return '1;
      return {$urandom, $urandom};
   endfunction

   task automatic random_password();
      int r;
      int len;
      r = $urandom_range(0, 9);
      case (r)
         0: len = 0;
         1: len = 1;
         2: len = 31;
         3: len = 32;
         4: len = 33;
         5: len = 63;
         default: len = $urandom_range(1, PW_BYTES);
      endcase
      set_password(random_pw_word(), random_pw_word(), random_pw_word(), random_pw_word(), len);
   endtask

   task automatic send_item(word_type d, logic l, output cipher_result_type r);
      int gap;
      req_valid <= 1'b1;
      req_data_in <= d;
      req_last_in <= l;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      if (lag_active) lagged_items++;
      r = cipher_transform(d, l);
      if (r.invalid) invalid_items++;
      transforms_due.push_back(r);
      items_sent++;
      gap = idle_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   always @(posedge clock) begin : rsp_pacing
      int r;
      if (rsp_hold_request != 0) begin
         run_left = rsp_hold_request;
         run_is_stall = 1'b1;
         rsp_hold_request = 0;
      end
      if (run_left == 0) begin
         r = $urandom_range(0, 99);
         if (!rsp_gaps) begin
            run_is_stall = 1'b0;
            run_left = 1;
         end else if ($urandom_range(0, 2) == 0) begin
            run_is_stall = 1'b1;
            if (r < 85) run_left = $urandom_range(1, 3);
            else if (r < 97) run_left = $urandom_range(4, 12);
            else run_left = $urandom_range(30, 80);
         end else begin
            run_is_stall = 1'b0;
            if (r < 90) run_left = $urandom_range(1, 10);
            else run_left = $urandom_range(20, 60);
         end
      end
      rsp_stall <= run_is_stall;
      run_left--;
   end

   always @(posedge clock) begin : check_results
      cipher_result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         results_seen++;
         if (transforms_due.size() == 0) begin
            $error("unexpected result item: data_out %h", rsp_data_out);
            failures++;
         end else begin
            want = transforms_due.pop_front();
            if (rsp_data_out !== want.data) begin
               $error("data_out: expected %h, actual %h", want.data, rsp_data_out);
               failures++;
            end
            if (rsp_invalid_word !== want.invalid) begin
               $error("invalid_word: expected %b, actual %b", want.invalid, rsp_invalid_word);
               failures++;
            end
            if (rsp_last_out !== want.last) begin
               $error("last_out: expected %b, actual %b", want.last, rsp_last_out);
               failures++;
            end
         end
      end
   end

   task automatic test_reset_defaults();
      cipher_result_type r;
      send_item(32'h0000_0000, 1'b0, r);
      send_item(32'hFFFF_FFFF, 1'b0, r);
      send_item(32'hA5A5_A500, 1'b0, r);
      send_item(32'h0000_00FF, 1'b1, r);
      wait_drained();
   endtask

   task automatic test_password_extremes();
      cipher_result_type r;
      set_password('1, '1, '1, '1, PW_BYTES);
      send_item(32'h0000_0000, 1'b0, r);
      send_item(32'h0000_0055, 1'b0, r);
      send_item(32'hFFFF_FFAA, 1'b1, r);
      wait_drained();
      set_password(64'h0706_0504_0302_0100, 64'h0F0E_0D0C_0B0A_0908,
                   64'h1716_1514_1312_1110, 64'h1F1E_1D1C_1B1A_1918, 0);
      send_item(32'h0000_0011, 1'b0, r);
      send_item(32'h0000_0022, 1'b1, r);
      wait_drained();
      set_length(63);
      send_item(32'h0000_0033, 1'b0, r);
      send_item(32'h0000_0044, 1'b1, r);
      wait_drained();
      set_length(33);
      send_item(32'h1234_5666, 1'b1, r);
      wait_drained();
   endtask

   task automatic test_decrypt_specials();
      cipher_result_type r;
      set_mode(MODE_DECRYPT);
      send_item(WORD_TABLE[0], 1'b0, r);
      send_item(WORD_TABLE[LAG_BYTES-1], 1'b0, r);
      send_item(32'h0000_0000, 1'b0, r);
      send_item(32'hFFFF_FFFF, 1'b0, r);
      send_item(WORD_TABLE[0] ^ 32'h0000_0001, 1'b0, r);
      send_item(WORD_TABLE[7], 1'b1, r);
      wait_drained();
      set_mode(MODE_ENCRYPT);
   endtask

   task automatic test_unused_index();
      cipher_result_type r;
      write_csr(CSR_SPARE_6, {$urandom, $urandom});
      write_csr(CSR_SPARE_7, '1);
      send_item($urandom, 1'b0, r);
      send_item($urandom, 1'b1, r);
      wait_drained();
   endtask

   // Encrypt random messages, then decrypt the predicted words, 3% with one bit flipped.
   task automatic test_round_trips();
      cipher_result_type r;
      word_type          cipher_words [$];
      logic              last_flags [$];
      word_type          w;
      int                total;
      int                len;
      for (int round = 0; round < ROUND_TRIPS; round++) begin
         send_gaps = ($urandom_range(0, 3) != 0);
         rsp_gaps = ($urandom_range(0, 3) != 0);
         random_password();
         set_mode(MODE_ENCRYPT);
         cipher_words.delete();
         last_flags.delete();
         total = 0;
         while (total < 90) begin
            if (total == 0 && round % 2 == 0)
               len = (round == 0) ? LAG_BYTES : LAG_BYTES + $urandom_range(1, 200);
            else
               len = message_length();
            for (int k = 0; k < len; k++) begin
               send_item($urandom, k == len - 1, r);
               cipher_words.push_back(r.data);
               last_flags.push_back(r.last);
            end
            total += len;
         end
         wait_drained();
         set_mode(MODE_DECRYPT);
         foreach (cipher_words[k]) begin
            w = cipher_words[k];
            if ($urandom_range(0, 99) < 3) w[$urandom_range(0, DATA_W - 1)] ^= 1'b1;
            send_item(w, last_flags[k], r);
         end
         wait_drained();
      end
   endtask

   task automatic test_mid_message_change();
      cipher_result_type r;
      send_gaps = 1'b1;
      rsp_gaps = 1'b1;
      set_mode(MODE_ENCRYPT);
      for (int k = 0; k < 248; k++) send_item($urandom, 1'b0, r);
      wait_drained();
      random_password();
      for (int k = 0; k < 20; k++) send_item($urandom, 1'b0, r);
      wait_drained();
      set_mode(MODE_DECRYPT);
      for (int k = 0; k < 10; k++) send_item(WORD_TABLE[$urandom_range(0, LAG_BYTES - 1)],
                                              1'b0, r);
      wait_drained();
      set_mode(MODE_ENCRYPT);
      set_length($urandom_range(1, PW_BYTES));
      for (int k = 0; k < 5; k++) send_item($urandom, k == 4, r);
      wait_drained();
   endtask

   task automatic test_decrypt_noise();
      cipher_result_type r;
      word_type          w;
      int                total;
      int                len;
      int                pick;
      send_gaps = 1'b1;
      rsp_gaps = 1'b1;
      random_password();
      set_mode(MODE_DECRYPT);
      total = 0;
      while (total < 200) begin
         len = message_length();
         for (int k = 0; k < len; k++) begin
            pick = $urandom_range(0, 99);
            w = WORD_TABLE[$urandom_range(0, LAG_BYTES - 1)];
            if (pick >= 95) w = ($urandom_range(0, 1) != 0) ? '1 : '0;
            else if (pick >= 85) w = $urandom;
            else if (pick >= 75) w[$urandom_range(0, DATA_W - 1)] ^= 1'b1;
            send_item(w, k == len - 1, r);
         end
         total += len;
      end
      wait_drained();
      set_mode(MODE_ENCRYPT);
   endtask

   task automatic test_output_hold();
      cipher_result_type r;
      send_gaps = 1'b0;
      rsp_gaps = 1'b1;
      rsp_hold_request = HOLD_CYCLES;
      for (int k = 0; k < 40; k++) send_item($urandom, k == 39, r);
      wait_drained();
   endtask

   task automatic test_sender_pause();
      cipher_result_type r;
      send_gaps = 1'b1;
      rsp_gaps = 1'b1;
      for (int k = 0; k < 16; k++) send_item($urandom, 1'b0, r);
      wait_drained();
      for (int k = 0; k < 16; k++) send_item($urandom, k == 15, r);
      wait_drained();
   endtask

   initial begin
      cur_mode = MODE_ENCRYPT;
      for (int i = 0; i < 4; i++) pw_word[i] = '0;
      pw_len = PW_LEN_W'(1);
      msg_pos = '0;
      lag_active = 1'b0;
      rebuild_group_order();

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      test_reset_defaults();
      test_password_extremes();
      test_decrypt_specials();
      test_unused_index();
      test_round_trips();
      test_mid_message_change();
      test_decrypt_noise();
      test_output_hold();
      test_sender_pause();

      wait_drained();
      repeat (20) @(posedge clock);
      if (transforms_due.size() != 0) begin
         $error("%0d result items never arrived", transforms_due.size());
         failures++;
      end
      $display("Sent %0d items and checked %0d results across %0d register writes.",
               items_sent, results_seen, csr_writes);
      $display("Of these, %0d items used the lagged history and %0d words were not in the table.",
               lagged_items, invalid_items);
      if (failures == 0) begin
         $display("tb_lagged_xor_table_cipher passed");
      end else begin
         $display("tb_lagged_xor_table_cipher failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
